### rtl/stm_pkg.sv
// shared types, constants and codes of the stretched texture modulate block
package stm_pkg;

  localparam int MAX_DIM      = 1024;
  localparam int TEX_SIDE     = 64;
  localparam int NUM_TEXTURES = 4;

  localparam int TEX_TEXELS = TEX_SIDE * TEX_SIDE;
  localparam int TEX_BITS   = $clog2(TEX_SIDE);
  localparam int TEX_IDX_W  = $clog2(TEX_TEXELS);
  localparam int TEX_ADDR_W = $clog2(NUM_TEXTURES * TEX_TEXELS);
  localparam int TEX_DEPTH  = NUM_TEXTURES * TEX_TEXELS;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int CNT_W      = $clog2(MAX_DIM);
  localparam int STEP_W     = $clog2(TEX_BITS + 1);

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int SLOT_W     = 2;
  localparam int CHAN_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SELECT = 2'd2,
    REG_ENABLE = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

endpackage

### rtl/stm_if.sv
// valid/ready channel interfaces for input and result items
interface stm_in_if;
  import stm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [SLOT_W-1:0]    load_slot;
  logic [TEX_IDX_W-1:0] texel_index;
  logic [CHAN_W-1:0]    texel_value;
  logic [CHAN_W-1:0]    pixel_red;
  logic [CHAN_W-1:0]    pixel_green;
  logic [CHAN_W-1:0]    pixel_blue;
  logic [CHAN_W-1:0]    pixel_alpha;

  modport source (
    output valid, kind, load_slot, texel_index, texel_value,
    output pixel_red, pixel_green, pixel_blue, pixel_alpha,
    input  ready
  );
  modport sink (
    input  valid, kind, load_slot, texel_index, texel_value,
    input  pixel_red, pixel_green, pixel_blue, pixel_alpha,
    output ready
  );
endinterface

interface stm_out_if;
  import stm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_alpha;
  logic              frame_last;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, frame_last,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, frame_last,
    output ready
  );
endinterface

### rtl/stm_ram.sv
// generic single write port ram with registered read
module stm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/stm_coord_div.sv
// bit-serial nearest texel coordinate: floor(pos*64/size), saturated to 63
module stm_coord_div
  import stm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [CNT_W-1:0]    pos,
  input  logic [DIM_W-1:0]    size,
  output logic                done,
  output logic [TEX_BITS-1:0] quot
);

  logic [DIM_W-1:0]    rem_r, rem_nxt;
  logic [TEX_BITS-1:0] q_r, q_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic                sat_r, sat_nxt;
  logic [DIM_W:0]      shifted;
  logic                fits;

  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, size};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    sat_nxt  = sat_r;
    done_nxt = 1'b0;
    if (start) begin
      // a position at or past the size lands on the last texel
      sat_nxt  = {1'b0, pos} >= size;
      rem_nxt  = sat_nxt ? '0 : {1'b0, pos};
      q_nxt    = '0;
      step_nxt = STEP_W'(TEX_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? DIM_W'(shifted - {1'b0, size}) : DIM_W'(shifted);
      q_nxt    = {q_r[TEX_BITS-2:0], fits};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
  end

  assign done = done_r;
  assign quot = sat_r ? '1 : q_r;

endmodule

### rtl/stm_shade.sv
// texel multiply of red, green and blue, then floored divide by 255
module stm_shade
  import stm_pkg::*;
(
  input  logic              clk,
  input  logic              capture,
  input  logic              enable,
  input  logic [CHAN_W-1:0] texel,
  input  pixel_t            pix_in,
  output pixel_t            pix_out
);

  localparam int PROD_W = 2 * CHAN_W;

  logic [CHAN_W-1:0] factor;
  logic [PROD_W-1:0] red_prod_r, green_prod_r, blue_prod_r;
  logic [CHAN_W-1:0] alpha_r;

  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] s;
    s = {1'b0, p} + (PROD_W+1)'(1) + (PROD_W+1)'(p >> CHAN_W);
    return s[PROD_W-1:CHAN_W];
  endfunction

  // a disabled texture scales by 255, which the divide undoes exactly
  assign factor = enable ? texel : '1;

  always_ff @(posedge clk) begin
    if (capture) begin
      red_prod_r   <= pix_in.red * factor;
      green_prod_r <= pix_in.green * factor;
      blue_prod_r  <= pix_in.blue * factor;
      alpha_r      <= pix_in.alpha;
    end
  end

  assign pix_out.red   = div255(red_prod_r);
  assign pix_out.green = div255(green_prod_r);
  assign pix_out.blue  = div255(blue_prod_r);
  assign pix_out.alpha = alpha_r;

endmodule

### rtl/stretched_texture_modulate.sv
// top level: texture modulate of a raster pixel stream with nearest stretch
// A load item writes one texel into the texture ram on acceptance and leaves the
// block ready for the next item. A pixel item passes through the bit-serial
// nearest-texel divides of row and column, the texture ram read, the multiply
// and the filling of the output register, and the next item is accepted only
// once the sequencer is back in idle.
// A result waiting on the output does not stop the next item from entering,
// but a pixel cannot leave the block until the previous result is taken.
// The texture ram has no reset; reading a texel never loaded gives garbage.
module stretched_texture_modulate
  import stm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  stm_in_if.sink                in_ch,
  stm_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [DIM_W-1:0]  width_r, height_r;
  logic [SLOT_W-1:0] select_r;
  logic              enable_r;

  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  width_cl, height_cl;
  logic              row_end, frame_end;

  logic              in_fire, pixel_fire, load_fire;
  logic              tex_on, tex_on_r;
  logic              last_r;
  pixel_t            pix_r, shaded;

  logic              col_done, row_done;
  logic [TEX_BITS-1:0] tex_x, tex_y;

  logic                  ram_we, ram_re;
  logic [TEX_ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CHAN_W-1:0]     ram_rdata;

  logic   out_valid_r, out_valid_nxt;
  pixel_t out_pix_r;
  logic   out_last_r;
  logic   out_load;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (32'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(64);
      height_r <= DIM_W'(64);
      select_r <= '0;
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_r  <= DIM_W'(cfg_data);
        REG_HEIGHT: height_r <= DIM_W'(cfg_data);
        REG_SELECT: select_r <= SLOT_W'(cfg_data);
        REG_ENABLE: enable_r <= cfg_data[0];
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pixel_fire  = in_fire && (kind_t'(in_ch.kind) == KIND_PIXEL);
  assign load_fire   = in_fire && (kind_t'(in_ch.kind) == KIND_LOAD);

  // raster counters
  assign width_cl  = clamp_dim(width_r);
  assign height_cl = clamp_dim(height_r);
  assign row_end   = ({1'b0, col_r} + DIM_W'(1)) >= width_cl;
  assign frame_end = row_end && (({1'b0, row_r} + DIM_W'(1)) >= height_cl);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (pixel_fire) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign tex_on = enable_r && (32'(select_r) < NUM_TEXTURES);

  always_ff @(posedge clk) begin
    if (pixel_fire) begin
      pix_r.red   <= in_ch.pixel_red;
      pix_r.green <= in_ch.pixel_green;
      pix_r.blue  <= in_ch.pixel_blue;
      pix_r.alpha <= in_ch.pixel_alpha;
      last_r      <= frame_end;
      tex_on_r    <= tex_on;
    end
  end

  stm_coord_div u_col_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pixel_fire),
    .pos   (col_r),
    .size  (width_cl),
    .done  (col_done),
    .quot  (tex_x)
  );

  stm_coord_div u_row_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pixel_fire),
    .pos   (row_r),
    .size  (height_cl),
    .done  (row_done),
    .quot  (tex_y)
  );

  // texture ram
  assign ram_we    = load_fire && (32'(in_ch.load_slot) < NUM_TEXTURES);
  assign ram_waddr = TEX_ADDR_W'(32'(in_ch.load_slot) * TEX_TEXELS
                                 + 32'(in_ch.texel_index));
  assign ram_re    = (state_r == ST_DIV) && col_done;
  assign ram_raddr = TEX_ADDR_W'(32'(select_r) * TEX_TEXELS
                                 + 32'(tex_y) * TEX_SIDE + 32'(tex_x));

  stm_ram #(
    .WIDTH (CHAN_W),
    .DEPTH (TEX_DEPTH)
  ) u_tex_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.texel_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stm_shade u_shade (
    .clk     (clk),
    .capture (state_r == ST_READ),
    .enable  (tex_on_r),
    .texel   (ram_rdata),
    .pix_in  (pix_r),
    .pix_out (shaded)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (pixel_fire) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (col_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r  <= shaded;
      out_last_r <= last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_red    = out_pix_r.red;
  assign out_ch.out_green  = out_pix_r.green;
  assign out_ch.out_blue   = out_pix_r.blue;
  assign out_ch.out_alpha  = out_pix_r.alpha;
  assign out_ch.frame_last = out_last_r;

`ifndef SYNTHESIS
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    col_done == row_done)
    else $error("row and column divides out of step");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    col_done |-> state_r == ST_DIV)
    else $error("divide finished outside the divide state");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result appeared without a finished pixel");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    pixel_fire && frame_end |=> col_r == '0 && row_r == '0)
    else $error("counters did not wrap at the end of the frame");
`endif

endmodule

### tb/sv/stm_modulate_checker.sv
// checker for the texture modulate block: predicts each modulated pixel and compares results
module stm_modulate_checker
  import stm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  stm_in_if                     in_mon,
  stm_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    load_count,
  output int                    pixel_count,
  output int                    frame_count,
  output int                    next_texel
);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              last;
  } shaded_t;

  logic [CHAN_W-1:0] tex_mem [TEX_DEPTH];
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [1:0]        select_reg;
  logic              enable_reg;
  int unsigned       col_pos;
  int unsigned       row_pos;
  int                results_checked;
  shaded_t           shaded_q[$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    load_count      = 0;
    pixel_count     = 0;
    frame_count     = 0;
    next_texel      = -1;
    results_checked = 0;
  end

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned texel_coord(int unsigned pos, int unsigned size);
    int unsigned t;
    t = (pos * TEX_SIDE) / size;
    if (t > TEX_SIDE - 1) t = TEX_SIDE - 1;
    return t;
  endfunction

  // texel that a pixel at the current raster position reads
  function automatic int unsigned texel_addr();
    return select_reg * TEX_TEXELS
           + texel_coord(row_pos, eff_dim(height_reg)) * TEX_SIDE
           + texel_coord(col_pos, eff_dim(width_reg));
  endfunction

  // advances the raster position as a side effect
  function automatic shaded_t modulate_pixel(pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned tv;
    int unsigned addr;
    logic        row_end;
    logic        frame_end;
    shaded_t     s;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    s.red   = px.red;
    s.green = px.green;
    s.blue  = px.blue;
    s.alpha = px.alpha;
    if (enable_reg && select_reg < NUM_TEXTURES) begin
      addr = texel_addr();
      tv = tex_mem[addr];
      s.red   = CHAN_W'((px.red * tv) / 255);
      s.green = CHAN_W'((px.green * tv) / 255);
      s.blue  = CHAN_W'((px.blue * tv) / 255);
    end
    row_end   = (col_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : ((row_pos + 1) & 10'h3FF);
    end else begin
      col_pos = (col_pos + 1) & 10'h3FF;
    end
    s.last = frame_end;
    return s;
  endfunction

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h expected %0h", results_checked, name, got,
                       want));
  endtask

  always @(posedge clk) begin
    shaded_t e;
    if (!rst_n) begin
      width_reg  = 11'd64;
      height_reg = 11'd64;
      select_reg = 2'd0;
      enable_reg = 1'b0;
      col_pos    = 0;
      row_pos    = 0;
      shaded_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_reg  = cfg_data;
          REG_HEIGHT: height_reg = cfg_data;
          REG_SELECT: select_reg = cfg_data[1:0];
          REG_ENABLE: enable_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        if (in_mon.kind == KIND_LOAD) begin
          if (in_mon.load_slot < NUM_TEXTURES)
            tex_mem[in_mon.load_slot * TEX_TEXELS + in_mon.texel_index] = in_mon.texel_value;
          load_count++;
        end else begin
          e = modulate_pixel('{in_mon.pixel_red, in_mon.pixel_green, in_mon.pixel_blue,
                               in_mon.pixel_alpha});
          shaded_q.push_back(e);
          pixel_count++;
          if (e.last) frame_count++;
        end
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (shaded_q.size() == 0) begin
          report("result with no pixel waiting for it");
        end else begin
          e = shaded_q.pop_front();
          check_field("red", out_mon.out_red, e.red);
          check_field("green", out_mon.out_green, e.green);
          check_field("blue", out_mon.out_blue, e.blue);
          check_field("alpha", out_mon.out_alpha, e.alpha);
          check_field("frame_last", {7'd0, out_mon.frame_last}, {7'd0, e.last});
        end
        results_checked++;
      end
    end
    pending = shaded_q.size();
    if (enable_reg && select_reg < NUM_TEXTURES)
      next_texel = int'(texel_addr());
    else
      next_texel = -1;
  end

endmodule

### tb/sv/tb_stretched_texture_modulate.sv
// testbench top: drives load and pixel items and register writes, gives the verdict
module tb_stretched_texture_modulate;
  import stm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEM_TARGET  = 420;
  localparam int IDLE_PCT     = 27;
  localparam int LONG_RUN     = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stm_in_if  in_ch ();
  stm_out_if out_ch ();

  int fail_count;
  int pending;
  int load_count;
  int pixel_count;
  int frame_count;
  int next_texel;
  int cycles = 0;
  int cfg_writes = 0;
  int items_sent = 0;
  bit steady = 1'b0;
  bit tex_written [TEX_DEPTH];

  stretched_texture_modulate i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stm_modulate_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .load_count  (load_count),
    .pixel_count (pixel_count),
    .frame_count (frame_count),
    .next_texel  (next_texel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px = '{rand_byte(), rand_byte(), rand_byte(), rand_byte()};
    return px;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return CFG_DATA_W'($urandom_range(1, 8));
    if (r < 80) return CFG_DATA_W'($urandom_range(9, 100));
    if (r < 88) return '0;
    if (r < 94) return CFG_DATA_W'(MAX_DIM);
    return CFG_DATA_W'($urandom_range(MAX_DIM + 1, 2047));
  endfunction

  // called and returns at a falling edge
  task automatic send_item(kind_t k, logic [SLOT_W-1:0] slot, logic [TEX_IDX_W-1:0] idx,
                           logic [CHAN_W-1:0] val, pixel_t px);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.load_slot   <= slot;
    in_ch.texel_index <= idx;
    in_ch.texel_value <= val;
    in_ch.pixel_red   <= px.red;
    in_ch.pixel_green <= px.green;
    in_ch.pixel_blue  <= px.blue;
    in_ch.pixel_alpha <= px.alpha;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_load(logic [SLOT_W-1:0] slot, logic [TEX_IDX_W-1:0] idx,
                           logic [CHAN_W-1:0] val);
    tex_written[int'(slot) * TEX_TEXELS + int'(idx)] = 1'b1;
    send_item(KIND_LOAD, slot, idx, val, pixel_t'($urandom));
  endtask

  // loads the texel the pixel will read first if it was never written
  task automatic send_pixel(pixel_t px);
    int addr;
    addr = next_texel;
    if (addr >= 0 && !tex_written[addr])
      send_load(SLOT_W'(addr / TEX_TEXELS), TEX_IDX_W'(addr % TEX_TEXELS), rand_byte());
    send_item(KIND_PIXEL, SLOT_W'($urandom), TEX_IDX_W'($urandom), CHAN_W'($urandom), px);
  endtask

  // hold the input until every pixel has come out, then let the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int                    n;
    int                    phase;
    logic [CFG_DATA_W-1:0] en_data;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_WIDTH;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_LOAD;
    in_ch.load_slot   = '0;
    in_ch.texel_index = '0;
    in_ch.texel_value = '0;
    in_ch.pixel_red   = '0;
    in_ch.pixel_green = '0;
    in_ch.pixel_blue  = '0;
    in_ch.pixel_alpha = '0;
    out_ch.ready      = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // texture disabled after reset: pixels pass unchanged
    send_pixel('{8'h00, 8'h00, 8'h00, 8'h00});
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});

    // one pixel frame, single texel, multiplier extremes
    drain();
    cfg_write(REG_WIDTH, 11'd1);
    cfg_write(REG_HEIGHT, 11'd1);
    cfg_write(REG_SELECT, 11'd1);
    cfg_write(REG_ENABLE, 11'd1);
    send_load(2'd1, 12'd0, 8'hFF);
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel('{8'hC8, 8'h64, 8'h01, 8'h4D});
    send_load(2'd1, 12'd0, 8'h00);
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_load(2'd1, 12'd0, 8'h80);
    send_pixel(rand_pixel());

    drain();
    cfg_write(REG_SELECT, 11'd3);
    send_pixel(rand_pixel());

    // sizes out of range: zero and above the maximum
    drain();
    cfg_write(REG_WIDTH, 11'd0);
    cfg_write(REG_HEIGHT, 11'd2047);
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
    drain();
    cfg_write(REG_WIDTH, 11'd1024);
    cfg_write(REG_HEIGHT, 11'd0);
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());

    // shrink the width mid-row so the column counter sits past the new size
    drain();
    cfg_write(REG_WIDTH, 11'd8);
    cfg_write(REG_HEIGHT, 11'd8);
    cfg_write(REG_ENABLE, 11'd0);
    repeat (5) send_pixel(rand_pixel());
    drain();
    cfg_write(REG_WIDTH, 11'd2);
    cfg_write(REG_ENABLE, 11'd1);
    repeat (3) send_pixel(rand_pixel());

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      cfg_write(REG_WIDTH, rand_dim());
      cfg_write(REG_HEIGHT, rand_dim());
      cfg_write(REG_SELECT, CFG_DATA_W'($urandom_range(0, 2047)));
      en_data    = CFG_DATA_W'($urandom_range(0, 2047));
      en_data[0] = ($urandom_range(0, 3) != 0);
      cfg_write(REG_ENABLE, en_data);
      steady <= (phase == 4);
      n = (phase == 4) ? 120 : $urandom_range(15, 45);
      for (int i = 0; i < n; i++) begin
        if (phase == 2 && i == n / 2) drain();
        if ($urandom_range(0, 99) < 15)
          send_load(SLOT_W'($urandom_range(0, 3)), TEX_IDX_W'($urandom_range(0, 4095)),
                    rand_byte());
        else
          send_pixel(rand_pixel());
      end
      phase++;
    end

    // widest row, then tallest column, stepping across texels along each
    drain();
    steady <= 1'b0;
    cfg_write(REG_WIDTH, 11'd1024);
    cfg_write(REG_HEIGHT, 11'd1);
    cfg_write(REG_SELECT, CFG_DATA_W'($urandom_range(0, 3)));
    cfg_write(REG_ENABLE, 11'd1);
    repeat (LONG_RUN) send_pixel(rand_pixel());
    drain();
    cfg_write(REG_WIDTH, 11'd1);
    cfg_write(REG_HEIGHT, 11'd1024);
    cfg_write(REG_SELECT, CFG_DATA_W'($urandom_range(0, 3)));
    repeat (LONG_RUN) send_pixel(rand_pixel());

    drain();
    $display("covered %0d texel loads and %0d pixels over %0d register writes",
             load_count, pixel_count, cfg_writes);
    $display("frame ends seen: %0d, mismatches: %0d", frame_count, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
rtl/stm_pkg.sv
rtl/stm_if.sv
rtl/stm_ram.sv
rtl/stm_coord_div.sv
rtl/stm_shade.sv
rtl/stretched_texture_modulate.sv
tb/sv/stm_modulate_checker.sv
tb/sv/tb_stretched_texture_modulate.sv
